FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

FILE: hw/rtl/ibe_pkg.sv
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared constants and types of the image border extrude block.
// ----------------------------------------------------------------------------
package ibe_pkg;

    localparam int MAX_WIDTH   = 128;   // power of two: row stride in the store
    localparam int MAX_HEIGHT  = 128;
    localparam int PAD_MAX     = 16;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int COORD_W = 8;
    localparam int PAD_W   = 5;
    localparam int SIZE_W  = 8;
    localparam int SIDES_W = 4;
    localparam int PIXEL_W = 32;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLICATE_SIDES = 2'd3;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // replicate_sides bit positions
    localparam int SIDE_TOP    = 0;
    localparam int SIDE_BOTTOM = 1;
    localparam int SIDE_LEFT   = 2;
    localparam int SIDE_RIGHT  = 3;

    // one classified operation, front to back
    typedef struct packed {
        logic               is_write;
        logic               fetch;      // read: value comes from the store
        logic               oor;        // read: coordinate beyond output image
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] pixel;
    } op_t;

endpackage

FILE: hw/rtl/ibe_front.sv
// ----------------------------------------------------------------------------
// ibe_front
// Holds the configuration, accepts items and maps each read coordinate of
// the padded image onto a store address, or onto zero / out of range.
// ----------------------------------------------------------------------------
module ibe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ibe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ibe_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: coord_x [7:0], coord_y [15:8], write_pixel [47:16]
    input  logic [47:0]                     s_tdata,
    // s_tuser: kind [0]
    input  logic                            s_tuser,
    output logic                            push,
    output ibe_pkg::op_t                    push_op,
    input  logic                            q_full
);

    logic [ibe_pkg::PAD_W-1:0]   pad_width_reg;
    logic [ibe_pkg::SIZE_W-1:0]  source_width_reg;
    logic [ibe_pkg::SIZE_W-1:0]  source_height_reg;
    logic [ibe_pkg::SIDES_W-1:0] sides_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_width_reg     <= '0;
            source_width_reg  <= ibe_pkg::SIZE_W'(ibe_pkg::MAX_WIDTH);
            source_height_reg <= ibe_pkg::SIZE_W'(ibe_pkg::MAX_HEIGHT);
            sides_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ibe_pkg::REG_PAD_WIDTH:
                    pad_width_reg <= cfg_wdata[ibe_pkg::PAD_W-1:0];
                ibe_pkg::REG_SOURCE_WIDTH:    source_width_reg  <= cfg_wdata;
                ibe_pkg::REG_SOURCE_HEIGHT:   source_height_reg <= cfg_wdata;
                ibe_pkg::REG_REPLICATE_SIDES:
                    sides_reg <= cfg_wdata[ibe_pkg::SIDES_W-1:0];
                default: ;
            endcase
        end
    end

    logic [ibe_pkg::COORD_W-1:0] x, y;
    logic [ibe_pkg::PIXEL_W-1:0] pix;
    logic                        kind;
    logic [ibe_pkg::PAD_W-1:0]   pad;
    logic [ibe_pkg::SIZE_W-1:0]  sw, sh;
    logic [ibe_pkg::COORD_W:0]   lim_x, lim_y, end_x, end_y;
    logic [ibe_pkg::COORD_W-1:0] dx, dy;
    logic [ibe_pkg::SIZE_W-1:0]  sw_m1, sh_m1;
    logic                        x_lo, y_lo, col_in, row_in, oor, wr_in;
    logic [ibe_pkg::COL_W-1:0]   sx;
    logic [ibe_pkg::ROW_W-1:0]   sy;
    logic                        fetch;

    assign x    = s_tdata[7:0];
    assign y    = s_tdata[15:8];
    assign pix  = s_tdata[47:16];
    assign kind = s_tuser;

    always_comb begin
        // effective register values after clamping
        pad = (pad_width_reg > ibe_pkg::PAD_W'(ibe_pkg::PAD_MAX))
            ? ibe_pkg::PAD_W'(ibe_pkg::PAD_MAX) : pad_width_reg;
        if (source_width_reg == '0)
            sw = ibe_pkg::SIZE_W'(1);
        else if (source_width_reg > ibe_pkg::SIZE_W'(ibe_pkg::MAX_WIDTH))
            sw = ibe_pkg::SIZE_W'(ibe_pkg::MAX_WIDTH);
        else
            sw = source_width_reg;
        if (source_height_reg == '0)
            sh = ibe_pkg::SIZE_W'(1);
        else if (source_height_reg > ibe_pkg::SIZE_W'(ibe_pkg::MAX_HEIGHT))
            sh = ibe_pkg::SIZE_W'(ibe_pkg::MAX_HEIGHT);
        else
            sh = source_height_reg;
    end

    always_comb begin
        end_x = {1'b0, sw} + (ibe_pkg::COORD_W+1)'(pad);
        end_y = {1'b0, sh} + (ibe_pkg::COORD_W+1)'(pad);
        lim_x = end_x + (ibe_pkg::COORD_W+1)'(pad);
        lim_y = end_y + (ibe_pkg::COORD_W+1)'(pad);
        oor   = ({1'b0, x} >= lim_x) || ({1'b0, y} >= lim_y);
        x_lo  = x < ibe_pkg::COORD_W'(pad);
        y_lo  = y < ibe_pkg::COORD_W'(pad);
        col_in = !x_lo && ({1'b0, x} < end_x);
        row_in = !y_lo && ({1'b0, y} < end_y);
        dx    = x - ibe_pkg::COORD_W'(pad);
        dy    = y - ibe_pkg::COORD_W'(pad);
        sw_m1 = sw - ibe_pkg::SIZE_W'(1);
        sh_m1 = sh - ibe_pkg::SIZE_W'(1);

        sx    = dx[ibe_pkg::COL_W-1:0];
        sy    = dy[ibe_pkg::ROW_W-1:0];
        fetch = 1'b0;
        if (col_in && row_in) begin
            fetch = 1'b1;
        end else if (col_in) begin
            // top or bottom band: copy the nearest source row
            if (y_lo) begin
                sy    = '0;
                fetch = sides_reg[ibe_pkg::SIDE_TOP];
            end else begin
                sy    = sh_m1[ibe_pkg::ROW_W-1:0];
                fetch = sides_reg[ibe_pkg::SIDE_BOTTOM];
            end
        end else if (row_in) begin
            if (x_lo) begin
                sx    = '0;
                fetch = sides_reg[ibe_pkg::SIDE_LEFT];
            end else begin
                sx    = sw_m1[ibe_pkg::COL_W-1:0];
                fetch = sides_reg[ibe_pkg::SIDE_RIGHT];
            end
        end

        wr_in = (x < sw) && (y < sh);

        push_op.is_write = (kind == ibe_pkg::KIND_WRITE);
        push_op.pixel    = pix;
        if (kind == ibe_pkg::KIND_WRITE) begin
            push_op.fetch = 1'b0;
            push_op.oor   = 1'b0;
            push_op.addr  = {y[ibe_pkg::ROW_W-1:0], x[ibe_pkg::COL_W-1:0]};
        end else begin
            push_op.fetch = fetch && !oor;
            push_op.oor   = oor;
            push_op.addr  = {sy, sx};
        end
    end

    assign s_tready = !q_full;
    // writes outside the source are dropped here
    assign push = s_tvalid && s_tready && ((kind == ibe_pkg::KIND_READ) || wr_in);

endmodule

FILE: hw/rtl/ibe_queue.sv
// ----------------------------------------------------------------------------
// ibe_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibe_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  ibe_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output ibe_pkg::op_t pop_op,
    output logic         empty
);

    ibe_pkg::op_t                 slot_reg [ibe_pkg::QUEUE_DEPTH];
    logic [ibe_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ibe_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ibe_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full   = (count_reg == ibe_pkg::QCNT_W'(ibe_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && empty)
    `ASSERT_AT(a_count_bound, aclk, aresetn, count_reg <= ibe_pkg::QCNT_W'(ibe_pkg::QUEUE_DEPTH))

endmodule

FILE: hw/rtl/ibe_back.sv
// ----------------------------------------------------------------------------
// ibe_back
// Executes operations against the source store: writes go straight in,
// reads go through a registered memory read and an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibe_back (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_empty,
    input  ibe_pkg::op_t q_op,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: read_pixel [31:0]
    output logic [31:0]  m_tdata,
    // m_tuser: out_of_range [0]
    output logic         m_tuser
);

    logic [ibe_pkg::PIXEL_W-1:0] store [ibe_pkg::STORE_DEPTH];

    logic                        rd_valid_reg, rd_valid_next;
    logic                        rd_fetch_reg, rd_oor_reg;
    logic [ibe_pkg::PIXEL_W-1:0] rd_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [ibe_pkg::PIXEL_W-1:0] out_data_reg;
    logic                        out_oor_reg;
    logic                        out_free, rd_move, rd_free, pop_read;

    assign out_free = !out_valid_reg || m_tready;
    assign rd_move  = rd_valid_reg && out_free;
    assign rd_free  = !rd_valid_reg || out_free;
    // writes never wait; a read needs room in the read stage
    assign q_pop    = !q_empty && (q_op.is_write || rd_free);
    assign pop_read = q_pop && !q_op.is_write;

    always_ff @(posedge aclk) begin
        if (q_pop && q_op.is_write)
            store[q_op.addr] <= q_op.pixel;
        if (pop_read)
            rd_data_reg <= store[q_op.addr];
    end

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (pop_read)
            rd_valid_next = 1'b1;
        else if (rd_move)
            rd_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (rd_move)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_read) begin
            rd_fetch_reg <= q_op.fetch;
            rd_oor_reg   <= q_op.oor;
        end
        if (rd_move) begin
            out_data_reg <= rd_fetch_reg ? rd_data_reg : '0;
            out_oor_reg  <= rd_oor_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_oor_reg;

    `ASSERT_AT(a_read_room, aclk, aresetn, pop_read |-> rd_free)
    `ASSERT_AT(a_oor_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0))

endmodule

FILE: hw/rtl/image_border_extrude.sv
// ----------------------------------------------------------------------------
// image_border_extrude
// Edge-replicate padding over a 128x128 ARGB32 source store.
// ----------------------------------------------------------------------------
// Path: a read item goes from the queue through the registered store read and
// the output register to m_tvalid; writes produce no item.
// Throughput: one item per cycle while the sink takes reads (m_tready high),
// set by the single store port in ibe_back.
// Reset: control and configuration registers return to their reset values;
// the source store is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
module image_border_extrude (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ibe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ibe_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: coord_x [7:0], coord_y [15:8], write_pixel [47:16]
    input  logic [47:0]                     s_tdata,
    // s_tuser: kind [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: read_pixel [31:0]
    output logic [31:0]                     m_tdata,
    // m_tuser: out_of_range [0]
    output logic                            m_tuser
);

    logic         push, q_full, q_pop, q_empty;
    ibe_pkg::op_t push_op, q_op;

    ibe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_op   (push_op),
        .q_full    (q_full)
    );

    ibe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_op),
        .empty   (q_empty)
    );

    ibe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_op     (q_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: tb/sv/image_border_extrude_tb.sv
// ----------------------------------------------------------------------------
// image_border_extrude_tb
// Self-checking bench for the border extrude block. A shadow copy of the
// source store and the registers predicts every read item; results are
// checked in order against that prediction. Directed cases cover the reset
// registers, each border band and a corner, disabled sides and register
// clamping. Random traffic then runs over several register settings, with
// the sender working in bursts; throughout, the sink stalls.
// ----------------------------------------------------------------------------
module image_border_extrude_tb;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 8;     // pipeline is 3 deep, writes leave no trace
    localparam int ITEMS_PER_PHASE = 35;
    localparam int RANDOM_PHASES   = 8;

    typedef struct packed {
        logic [ibe_pkg::PIXEL_W-1:0] pixel;
        logic                        oor;
    } read_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [ibe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ibe_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [47:0]                   s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;
    logic                          m_tuser;

    // shadow of the block's state
    logic [ibe_pkg::PIXEL_W-1:0] shadow_store [ibe_pkg::STORE_DEPTH];
    bit                          shadow_written [ibe_pkg::STORE_DEPTH];
    logic [ibe_pkg::PAD_W-1:0]   pad_reg;
    logic [ibe_pkg::SIZE_W-1:0]  width_reg;
    logic [ibe_pkg::SIZE_W-1:0]  height_reg;
    logic [ibe_pkg::SIDES_W-1:0] sides_reg;

    read_result_t pending_reads [$];
    read_result_t head_read;

    int cycle_count;
    int mismatch_count;
    int results_checked;
    int writes_sent;
    int reads_sent;
    int oor_reads;
    int band_reads;
    int settings_used;
    int burst_left;
    logic [7:0] sink_phase;

    image_border_extrude dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, pending_reads.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // sink stall pattern: free running, light stalls, coin flip, long stalls
    always @(posedge aclk) begin
        sink_phase <= sink_phase + 8'd1;
        case (sink_phase[7:6])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (sink_phase[3:0] < 4'd3);
        endcase
    end

    task automatic flag_mismatch(input string msg);
        $display("cycle %0d: mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                flag_mismatch($sformatf("unexpected item pixel=%08h oor=%0b", m_tdata, m_tuser));
            end else begin
                head_read = pending_reads.pop_front();
                if (m_tdata !== head_read.pixel)
                    flag_mismatch($sformatf("read_pixel %08h, want %08h",
                                            m_tdata, head_read.pixel));
                if (m_tuser !== head_read.oor)
                    flag_mismatch($sformatf("out_of_range %0b, want %0b",
                                            m_tuser, head_read.oor));
                results_checked++;
            end
        end
    end

    function automatic void current_geometry(output int pad, output int sw, output int sh);
        pad = (pad_reg > ibe_pkg::PAD_MAX) ? ibe_pkg::PAD_MAX : int'(pad_reg);
        sw  = (width_reg == 0) ? 1 :
              (width_reg > ibe_pkg::MAX_WIDTH) ? ibe_pkg::MAX_WIDTH : int'(width_reg);
        sh  = (height_reg == 0) ? 1 :
              (height_reg > ibe_pkg::MAX_HEIGHT) ? ibe_pkg::MAX_HEIGHT : int'(height_reg);
    endfunction

    // Maps an output coordinate onto the store. hit says a stored pixel is
    // returned; band marks a coordinate in a border band (not a corner).
    function automatic void locate_source(input int x, input int y, output bit oor,
                                          output bit hit, output bit band, output int addr);
        int pad, sw, sh, sx, sy;
        bit col_in, row_in;
        current_geometry(pad, sw, sh);
        oor    = (x >= sw + 2 * pad) || (y >= sh + 2 * pad);
        col_in = (x >= pad) && (x < pad + sw);
        row_in = (y >= pad) && (y < pad + sh);
        hit  = 1'b0;
        band = 1'b0;
        sx   = 0;
        sy   = 0;
        if (!oor) begin
            if (col_in && row_in) begin
                hit = 1'b1;
                sx  = x - pad;
                sy  = y - pad;
            end else if (col_in) begin
                band = 1'b1;
                sx   = x - pad;
                if (y < pad) begin
                    hit = sides_reg[ibe_pkg::SIDE_TOP];
                    sy  = 0;
                end else begin
                    hit = sides_reg[ibe_pkg::SIDE_BOTTOM];
                    sy  = sh - 1;
                end
            end else if (row_in) begin
                band = 1'b1;
                sy   = y - pad;
                if (x < pad) begin
                    hit = sides_reg[ibe_pkg::SIDE_LEFT];
                    sx  = 0;
                end else begin
                    hit = sides_reg[ibe_pkg::SIDE_RIGHT];
                    sx  = sw - 1;
                end
            end
        end
        addr = sy * ibe_pkg::MAX_WIDTH + sx;
    endfunction

    // Drives one item and holds it until accepted; s_tvalid stays high so
    // a following item can go out in the next cycle.
    task automatic send_item(input logic kind, input logic [7:0] x, input logic [7:0] y,
                             input logic [ibe_pkg::PIXEL_W-1:0] pixel);
        bit oor, hit, band;
        int addr, pad, sw, sh;
        read_result_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pixel, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == ibe_pkg::KIND_WRITE) begin
            writes_sent++;
            current_geometry(pad, sw, sh);
            if (x < sw && y < sh) begin
                shadow_store[int'(y) * ibe_pkg::MAX_WIDTH + int'(x)]   = pixel;
                shadow_written[int'(y) * ibe_pkg::MAX_WIDTH + int'(x)] = 1'b1;
            end
        end else begin
            reads_sent++;
            locate_source(x, y, oor, hit, band, addr);
            want.oor   = oor;
            want.pixel = hit ? shadow_store[addr] : '0;
            if (oor) oor_reads++;
            if (band && hit) band_reads++;
            pending_reads = {pending_reads, want};
        end
    endtask

    // reads never touch a store entry that was not written first
    task automatic read_at(input int x, input int y);
        bit oor, hit, band;
        int addr;
        locate_source(x, y, oor, hit, band, addr);
        if (hit && !shadow_written[addr])
            send_item(ibe_pkg::KIND_WRITE, 8'(addr % ibe_pkg::MAX_WIDTH),
                      8'(addr / ibe_pkg::MAX_WIDTH), $urandom);
        send_item(ibe_pkg::KIND_READ, 8'(x), 8'(y), $urandom);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic pace_sender();
        if (burst_left == 0) begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ibe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ibe_pkg::CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            ibe_pkg::REG_PAD_WIDTH:       pad_reg    = value[ibe_pkg::PAD_W-1:0];
            ibe_pkg::REG_SOURCE_WIDTH:    width_reg  = value[ibe_pkg::SIZE_W-1:0];
            ibe_pkg::REG_SOURCE_HEIGHT:   height_reg = value[ibe_pkg::SIZE_W-1:0];
            ibe_pkg::REG_REPLICATE_SIDES: sides_reg  = value[ibe_pkg::SIDES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] pad, input logic [7:0] sw,
                              input logic [7:0] sh, input logic [7:0] sides);
        drain_results();
        write_reg(ibe_pkg::REG_PAD_WIDTH, pad);
        write_reg(ibe_pkg::REG_SOURCE_WIDTH, sw);
        write_reg(ibe_pkg::REG_SOURCE_HEIGHT, sh);
        write_reg(ibe_pkg::REG_REPLICATE_SIDES, sides);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // registers at reset: no border, full 128x128 source
    task automatic test_reset_defaults();
        send_item(ibe_pkg::KIND_WRITE, 8'd127, 8'd127, 32'hFFFF_FFFF);
        send_item(ibe_pkg::KIND_WRITE, 8'd4, 8'd0, $urandom);
        send_item(ibe_pkg::KIND_WRITE, 8'd0, 8'd3, $urandom);
        read_at(127, 127);
        read_at(128, 5);
        read_at(3, 200);
    endtask

    // pad 2 around a 4x3 source, all sides on
    task automatic test_edge_regions();
        set_config(8'd2, 8'd4, 8'd3, 8'hF);
        send_item(ibe_pkg::KIND_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(ibe_pkg::KIND_WRITE, 8'd3, 8'd1, 32'h0000_0000);
        send_item(ibe_pkg::KIND_WRITE, 8'd1, 8'd2, $urandom);
        // both fall outside the source and must not land in the store
        send_item(ibe_pkg::KIND_WRITE, 8'd4, 8'd0, $urandom);
        send_item(ibe_pkg::KIND_WRITE, 8'd0, 8'd3, $urandom);
        read_at(2, 2);      // interior
        read_at(3, 0);      // top band
        read_at(3, 6);      // bottom band
        read_at(0, 3);      // left band
        read_at(7, 3);      // right band
        read_at(0, 0);      // corner
        read_at(8, 0);      // just past the right edge
    endtask

    task automatic test_disabled_sides();
        set_config(8'd1, 8'd5, 8'd4,
                   8'((1 << ibe_pkg::SIDE_BOTTOM) | (1 << ibe_pkg::SIDE_RIGHT)));
        read_at(5, 1);      // pixels behind the ignored writes
        read_at(1, 4);
        read_at(2, 0);
        read_at(0, 2);
        read_at(2, 5);
        read_at(6, 2);
    endtask

    // oversized pad, zero width and oversized height all saturate
    task automatic test_register_clamping();
        set_config(8'd31, 8'd0, 8'd255, 8'hFF);
        read_at(16, 16);
        read_at(0, 20);
        read_at(16, 0);
        read_at(16, 150);
        read_at(17, 30);
        read_at(33, 0);
        read_at(16, 160);
    endtask

    function automatic int edge_coord(input int pad, input int size);
        int c;
        case ($urandom_range(0, 6))
            0: c = 0;
            1: c = pad - 1;
            2: c = pad;
            3: c = pad + size - 1;
            4: c = pad + size;
            5: c = size + 2 * pad - 1;
            default: c = size + 2 * pad;
        endcase
        return (c < 0) ? 0 : c;
    endfunction

    task automatic test_random_traffic();
        int phase, n, pad, sw, sh, x, y, pick;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(8'd0, 8'd128, 8'd128, 8'h0);
                1: set_config(8'd16, 8'd128, 8'd128, 8'hF);
                2: set_config(8'd16, 8'd1, 8'd1, 8'hF);
                3: set_config(8'd255, 8'd0, 8'd255, 8'($urandom_range(0, 255)));
                default: set_config(8'($urandom_range(0, 20)), 8'($urandom_range(1, 24)),
                                    8'($urandom_range(1, 24)), 8'($urandom_range(0, 15)));
            endcase
            current_geometry(pad, sw, sh);
            burst_left = $urandom_range(0, 40);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 28) begin
                    send_item(ibe_pkg::KIND_WRITE, 8'($urandom_range(0, sw - 1)),
                              8'($urandom_range(0, sh - 1)), $urandom);
                end else if (pick < 40) begin
                    send_item(ibe_pkg::KIND_WRITE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), $urandom);
                end else begin
                    if (pick < 73) begin
                        x = $urandom_range(0, sw + 2 * pad - 1);
                        y = $urandom_range(0, sh + 2 * pad - 1);
                    end else if (pick < 88) begin
                        x = edge_coord(pad, sw);
                        y = edge_coord(pad, sh);
                    end else begin
                        x = $urandom_range(0, 255);
                        y = $urandom_range(0, 255);
                    end
                    read_at(x, y);
                end
                pace_sender();
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = ibe_pkg::KIND_WRITE;
        m_tready        = 1'b0;
        sink_phase      = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        results_checked = 0;
        writes_sent     = 0;
        reads_sent      = 0;
        oor_reads       = 0;
        band_reads      = 0;
        settings_used   = 0;
        burst_left      = 0;
        pad_reg         = '0;
        width_reg       = 8'd128;
        height_reg      = 8'd128;
        sides_reg       = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_edge_regions();
        test_disabled_sides();
        test_register_clamping();
        test_random_traffic();
        drain_results();

        $display("%0d writes and %0d reads over %0d register settings, %0d results checked",
                 writes_sent, reads_sent, settings_used + 1, results_checked);
        $display("reads hit %0d replicated border pixels and %0d out-of-range coordinates",
                 band_reads, oor_reads);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
